// ===== hw/rtl/channel_window_hit_clusterer_macros.svh =====
// ----------------------------------------------------------------------------
// channel window hit clusterer: assertion macros
// checks for the clusterer logic, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef CHANNEL_WINDOW_HIT_CLUSTERER_MACROS_SVH
`define CHANNEL_WINDOW_HIT_CLUSTERER_MACROS_SVH

`ifndef SYNTHESIS

// consequent holds in the same cycle as the antecedent
`define CWHC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cwhc same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define CWHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cwhc next-cycle check failed");

`else

`define CWHC_ASSERT_SAME(label, clk, rst, ante, cons)
`define CWHC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/cwhc_pkg.sv =====
// ----------------------------------------------------------------------------
// cwhc_pkg
// types and constants shared by the channel window hit clusterer
// ----------------------------------------------------------------------------
package cwhc_pkg;

   // csr address width: three 32-bit registers at byte offsets 0, 4, 8
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] REG_MIN_HITS      = 2'd0;
   localparam logic [1:0] REG_WINDOW_TICKS  = 2'd1;
   localparam logic [1:0] REG_CHANNEL_REACH = 2'd2;

   localparam logic [15:0] MIN_HITS_RESET      = 16'd2;
   localparam logic [31:0] WINDOW_TICKS_RESET  = 32'd8000;
   localparam logic [15:0] CHANNEL_REACH_RESET = 16'd50;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [47:0] ADC_MAX   = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [63:0] hit_time;
      logic [31:0] hit_channel;
      logic [63:0] hit_peak_time;
      logic [15:0] hit_peak_adc;
      logic [31:0] hit_adc_sum;
      logic [15:0] hit_detector;
   } hit_type;

   typedef struct packed {
      logic [31:0] group_first_channel;
      logic [31:0] group_last_channel;
      logic [63:0] group_start_time;
      logic [63:0] group_end_time;
      logic [63:0] group_peak_time;
      logic [31:0] group_peak_channel;
      logic [15:0] group_peak_adc;
      logic [47:0] group_adc_total;
      logic [15:0] group_detector;
      logic [15:0] group_hits;
   } group_type;

   typedef struct packed {
      logic [15:0] min_hits;
      logic [31:0] window_ticks;
      logic [15:0] channel_reach;
   } cfg_type;

endpackage

// ===== hw/rtl/cwhc_csr.sv =====
// ----------------------------------------------------------------------------
// cwhc_csr
// apb register file holding the clusterer configuration
// ----------------------------------------------------------------------------
module cwhc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cwhc_pkg::CSR_AW-1:0]     paddr,
   input  logic [cwhc_pkg::CSR_DW-1:0]     pwdata,
   output logic [cwhc_pkg::CSR_DW-1:0]     prdata,
   output logic                            pready,
   output cwhc_pkg::cfg_type               cfg
);
   import cwhc_pkg::*;

   logic [15:0] min_hits_ff;
   logic [31:0] window_ticks_ff;
   logic [15:0] channel_reach_ff;
   logic [15:0] min_hits_in;
   logic [31:0] window_ticks_in;
   logic [15:0] channel_reach_in;
   logic        write_en;
   logic [1:0]  reg_index;

   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[CSR_AW-1:2];
   assign pready    = 1'b1;

   always_comb begin
      min_hits_in      = min_hits_ff;
      window_ticks_in  = window_ticks_ff;
      channel_reach_in = channel_reach_ff;
      if (write_en) begin
         case (reg_index)
            REG_MIN_HITS:      min_hits_in      = pwdata[15:0];
            REG_WINDOW_TICKS:  window_ticks_in  = pwdata;
            REG_CHANNEL_REACH: channel_reach_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MIN_HITS:      prdata = {16'd0, min_hits_ff};
         REG_WINDOW_TICKS:  prdata = window_ticks_ff;
         REG_CHANNEL_REACH: prdata = {16'd0, channel_reach_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_hits_ff      <= MIN_HITS_RESET;
         window_ticks_ff  <= WINDOW_TICKS_RESET;
         channel_reach_ff <= CHANNEL_REACH_RESET;
      end else begin
         min_hits_ff      <= min_hits_in;
         window_ticks_ff  <= window_ticks_in;
         channel_reach_ff <= channel_reach_in;
      end
   end

   assign cfg.min_hits      = min_hits_ff;
   assign cfg.window_ticks  = window_ticks_ff;
   assign cfg.channel_reach = channel_reach_ff;

endmodule

// ===== hw/rtl/cwhc_core.sv =====
// ----------------------------------------------------------------------------
// cwhc_core
// input register, running group state and result register
// ----------------------------------------------------------------------------
`include "channel_window_hit_clusterer_macros.svh"

module cwhc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  cwhc_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cwhc_pkg::hit_type    req_hit,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cwhc_pkg::group_type  rsp_group
);
   import cwhc_pkg::*;

   // input stage
   logic        in_valid_ff;
   logic        in_valid_in;
   hit_type     in_hit_ff;

   // group state
   logic               open_ff;
   logic               open_in;
   logic [63:0]        start_time_ff, start_time_in;
   logic [63:0]        end_time_ff, end_time_in;
   logic [31:0]        first_channel_ff, first_channel_in;
   logic [31:0]        last_channel_ff, last_channel_in;
   logic signed [33:0] low_ff, low_in;
   logic signed [33:0] high_ff, high_in;
   logic [15:0]        count_ff, count_in;
   logic [47:0]        adc_total_ff, adc_total_in;
   logic [15:0]        best_peak_ff, best_peak_in;
   logic [31:0]        best_channel_ff, best_channel_in;
   logic [63:0]        best_time_ff, best_time_in;
   logic [15:0]        first_detector_ff, first_detector_in;

   // result stage
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   group_type   rsp_group_ff;
   group_type   group_now;

   logic               out_free;
   logic               proc_fire;
   logic               closes;
   logic               in_window;
   logic               emit;
   logic               do_open;
   logic               do_join;
   logic [63:0]        elapsed;
   logic signed [33:0] chan_s;
   logic signed [33:0] reach_s;
   logic signed [33:0] low_cand;
   logic signed [33:0] high_cand;
   logic [48:0]        adc_sum;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // only an item that emits has to wait for the result register
   assign proc_fire = in_valid_ff && (out_free || !emit);
   assign req_ready = !in_valid_ff || proc_fire;

   // unsigned wrapping distance from the group start
   assign elapsed   = in_hit_ff.hit_time - start_time_ff;
   assign closes    = open_ff && (elapsed > {32'd0, cfg.window_ticks});
   assign chan_s    = signed'({2'b00, in_hit_ff.hit_channel});
   assign reach_s   = signed'({18'd0, cfg.channel_reach});
   assign low_cand  = chan_s - reach_s;
   assign high_cand = chan_s + reach_s;
   assign in_window = !(chan_s > high_ff) && !(chan_s < low_ff);
   assign emit      = closes && (count_ff >= cfg.min_hits);
   assign do_open   = proc_fire && (!open_ff || closes);
   assign do_join   = proc_fire && open_ff && !closes && in_window;
   assign adc_sum   = {1'b0, adc_total_ff} + {17'd0, in_hit_ff.hit_adc_sum};

   always_comb begin
      open_in           = open_ff;
      start_time_in     = start_time_ff;
      end_time_in       = end_time_ff;
      first_channel_in  = first_channel_ff;
      last_channel_in   = last_channel_ff;
      low_in            = low_ff;
      high_in           = high_ff;
      count_in          = count_ff;
      adc_total_in      = adc_total_ff;
      best_peak_in      = best_peak_ff;
      best_channel_in   = best_channel_ff;
      best_time_in      = best_time_ff;
      first_detector_in = first_detector_ff;
      if (do_open) begin
         open_in           = 1'b1;
         start_time_in     = in_hit_ff.hit_time;
         end_time_in       = in_hit_ff.hit_time;
         first_channel_in  = in_hit_ff.hit_channel;
         last_channel_in   = in_hit_ff.hit_channel;
         low_in            = low_cand;
         high_in           = high_cand;
         count_in          = 16'd1;
         adc_total_in      = {16'd0, in_hit_ff.hit_adc_sum};
         first_detector_in = in_hit_ff.hit_detector;
         // best peak restarts at zero, so only a non-zero peak is taken
         if (in_hit_ff.hit_peak_adc != 16'd0) begin
            best_peak_in    = in_hit_ff.hit_peak_adc;
            best_channel_in = in_hit_ff.hit_channel;
            best_time_in    = in_hit_ff.hit_peak_time;
         end else begin
            best_peak_in    = '0;
            best_channel_in = '0;
            best_time_in    = '0;
         end
      end else if (do_join) begin
         end_time_in     = in_hit_ff.hit_time;
         last_channel_in = in_hit_ff.hit_channel;
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 16'd1;
         end
         adc_total_in = adc_sum[48] ? ADC_MAX : adc_sum[47:0];
         if (in_hit_ff.hit_peak_adc > best_peak_ff) begin
            best_peak_in    = in_hit_ff.hit_peak_adc;
            best_channel_in = in_hit_ff.hit_channel;
            best_time_in    = in_hit_ff.hit_peak_time;
         end
         if (low_cand < low_ff) begin
            low_in = low_cand;
         end
         if (high_cand > high_ff) begin
            high_in = high_cand;
         end
      end
   end

   always_comb begin
      group_now.group_first_channel = first_channel_ff;
      group_now.group_last_channel  = last_channel_ff;
      group_now.group_start_time    = start_time_ff;
      group_now.group_end_time      = end_time_ff;
      group_now.group_peak_time     = best_time_ff;
      group_now.group_peak_channel  = best_channel_ff;
      group_now.group_peak_adc      = best_peak_ff;
      group_now.group_adc_total     = adc_total_ff;
      group_now.group_detector      = first_detector_ff;
      group_now.group_hits          = count_ff;
   end

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !proc_fire);
   assign rsp_valid_in = (proc_fire && emit) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload fields are only read while an item is held, group fields only once a group is open
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_hit_ff <= req_hit;
      end
      if (proc_fire && emit) begin
         rsp_group_ff <= group_now;
      end
      start_time_ff     <= start_time_in;
      end_time_ff       <= end_time_in;
      first_channel_ff  <= first_channel_in;
      last_channel_ff   <= last_channel_in;
      low_ff            <= low_in;
      high_ff           <= high_in;
      count_ff          <= count_in;
      adc_total_ff      <= adc_total_in;
      best_peak_ff      <= best_peak_in;
      best_channel_ff   <= best_channel_in;
      best_time_ff      <= best_time_in;
      first_detector_ff <= first_detector_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_group = rsp_group_ff;

   `CWHC_ASSERT_NEXT(a_open_after_item, clock, reset, proc_fire, open_ff)
   `CWHC_ASSERT_SAME(a_count_when_open, clock, reset, open_ff, count_ff != 16'd0)
   `CWHC_ASSERT_SAME(a_bounds_ordered, clock, reset, open_ff, low_ff <= high_ff)
   `CWHC_ASSERT_NEXT(a_stalled_item_kept, clock, reset, in_valid_ff && !proc_fire,
                     in_valid_ff && $stable(in_hit_ff))
   `CWHC_ASSERT_NEXT(a_emit_shows_result, clock, reset, proc_fire && emit, rsp_valid_ff)

endmodule

// ===== hw/rtl/channel_window_hit_clusterer.sv =====
// ----------------------------------------------------------------------------
// channel_window_hit_clusterer: groups detector hits by time and channel window
// result: the input register holds the closing hit, then the result register its group
// throughput: one hit per cycle; only a hit that emits waits while a result is held
// reset: synchronous, clears the open group and pipeline valids, restores register defaults
// ----------------------------------------------------------------------------
module channel_window_hit_clusterer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cwhc_pkg::hit_type               req_hit,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cwhc_pkg::group_type             rsp_group,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cwhc_pkg::CSR_AW-1:0]     paddr,
   input  logic [cwhc_pkg::CSR_DW-1:0]     pwdata,
   output logic [cwhc_pkg::CSR_DW-1:0]     prdata,
   output logic                            pready
);
   import cwhc_pkg::*;

   cfg_type cfg;

   cwhc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cwhc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_hit   (req_hit),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_group (rsp_group)
   );

endmodule
